/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file vpc_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge, reset included.
`define VPC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while out of reset.
`define VPC_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* rtl/vpc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vpc_pkg
// Types, constants and helper functions of the virtual counter extender.
// ----------------------------------------------------------------------------
package vpc_pkg;

    localparam int COUNTER_COUNT = 2;   // hardware counters kept (1..8; at most IN_COUNTERS take effect)
    localparam int IN_COUNTERS   = 2;   // counters present on the ports
    localparam int USED_COUNTERS = (COUNTER_COUNT < IN_COUNTERS) ? COUNTER_COUNT
                                                                 : IN_COUNTERS;

    localparam int TOTAL_W = 64;
    localparam int RAW_W   = 40;
    localparam int LOW_W   = 31;

    localparam logic [RAW_W-1:0] TOP_BITS = 40'hff_8000_0000;

    typedef enum logic [1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_BIND    = 2'd1,
        KIND_RESTORE = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]         kind;
        logic [RAW_W-1:0]   raw_count0;
        logic [RAW_W-1:0]   raw_count1;
        logic [TOTAL_W-1:0] raw_stamp;
        logic [TOTAL_W-1:0] preset0;
        logic [TOTAL_W-1:0] preset1;
    } t_item;

    typedef struct packed {
        logic [TOTAL_W-1:0] total0;
        logic [TOTAL_W-1:0] total1;
        logic [TOTAL_W-1:0] stamp_total;
        logic [RAW_W-1:0]   reload0;
        logic [RAW_W-1:0]   reload1;
    } t_result;

    // bits 39..31 all set: counter runs the full 40-bit range
    function automatic logic wide_mode(input logic [RAW_W-1:0] v);
        return (v & TOP_BITS) == TOP_BITS;
    endfunction

    function automatic logic [RAW_W-1:0] reload_of(input logic [TOTAL_W-1:0] total);
        logic [RAW_W-1:0] lo;
        lo = total[RAW_W-1:0];
        return wide_mode(lo) ? lo : {{(RAW_W-LOW_W){1'b0}}, lo[LOW_W-1:0]};
    endfunction

    function automatic logic [RAW_W-1:0] wrapped_delta(input logic [RAW_W-1:0] raw,
                                                       input logic [RAW_W-1:0] reload);
        logic [LOW_W-1:0] d31;
        d31 = raw[LOW_W-1:0] - reload[LOW_W-1:0];
        return wide_mode(reload) ? (raw - reload) : {{(RAW_W-LOW_W){1'b0}}, d31};
    endfunction

endpackage
`default_nettype wire

/* rtl/virtual_perf_counter_extend.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// virtual_perf_counter_extend
// Extends two 40-bit event counters and a 64-bit timestamp to 64-bit totals.
// ----------------------------------------------------------------------------
// Takes one word per clock while not stalled and returns one result word per
// input word, in order. A word goes through an input register, a
// combinational update of the counter state and a two-entry result buffer.
// Once the buffer has room, the word is committed to the counter state and
// its result pushed into the buffer. The input stalls only while the input
// register holds a word and the result buffer is full. kind 0 (sample) adds
// each counter's wrapped difference against its reload value to the 64-bit
// total, adds the timestamp delta to the timestamp total and refreshes the
// reload values and the timestamp baseline. kind 1 (bind) loads the presets,
// clears the timestamp total and derives the reload values. kind 2 (restore)
// records the timestamp baseline. kind 3 changes nothing. Every result shows
// the state after its word. A reload value is the low 40 bits of the total
// when bits 39..31 are all set, else the low 31 bits; the sample difference
// wraps at 2^40 or 2^31 to match. Totals wrap at 2^64. Reset clears all
// totals, reload values and the baseline.
// ----------------------------------------------------------------------------
module virtual_perf_counter_extend
    import vpc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input channel
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [1:0]          i_kind,
    input  wire logic [RAW_W-1:0]    i_raw_count0,
    input  wire logic [RAW_W-1:0]    i_raw_count1,
    input  wire logic [TOTAL_W-1:0]  i_raw_stamp,
    input  wire logic [TOTAL_W-1:0]  i_preset0,
    input  wire logic [TOTAL_W-1:0]  i_preset1,
    // result channel
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [TOTAL_W-1:0]       o_total0,
    output logic [TOTAL_W-1:0]       o_total1,
    output logic [TOTAL_W-1:0]       o_stamp_total,
    output logic [RAW_W-1:0]         o_reload0,
    output logic [RAW_W-1:0]         o_reload1
);

    // input register
    t_item   r_item;
    logic    r_in_valid;

    logic    in_accept;
    logic    advance;     // word in the input register commits this cycle
    logic    buf_full;
    t_result core_result;
    t_result out_word;

    // the word only waits when the result buffer has no room
    assign advance   = r_in_valid && !buf_full;
    assign o_stall   = r_in_valid && buf_full;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.kind       <= i_kind;
            r_item.raw_count0 <= i_raw_count0;
            r_item.raw_count1 <= i_raw_count1;
            r_item.raw_stamp  <= i_raw_stamp;
            r_item.preset0    <= i_preset0;
            r_item.preset1    <= i_preset1;
        end
    end

    // state update: result is the state after this word
    vpc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .o_result  (core_result)
    );

    // result buffer
    vpc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_data  (core_result),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_word)
    );

    assign o_total0      = out_word.total0;
    assign o_total1      = out_word.total1;
    assign o_stamp_total = out_word.stamp_total;
    assign o_reload0     = out_word.reload0;
    assign o_reload1     = out_word.reload1;

endmodule
`default_nettype wire

/* rtl/vpc_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vpc_core
// Counter state and the combinational update for one word.
// ----------------------------------------------------------------------------
module vpc_core
    import vpc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_advance,   // commit this word's update
    input  wire t_item   i_item,
    output t_result      o_result     // state as it stands after the word
);

    logic [TOTAL_W-1:0] r_total  [USED_COUNTERS];
    logic [RAW_W-1:0]   r_reload [USED_COUNTERS];
    logic [TOTAL_W-1:0] r_stamp_sum;
    logic [TOTAL_W-1:0] r_stamp_base;

    logic [TOTAL_W-1:0] n_total  [USED_COUNTERS];
    logic [RAW_W-1:0]   n_reload [USED_COUNTERS];
    logic [TOTAL_W-1:0] n_stamp_sum;
    logic [TOTAL_W-1:0] n_stamp_base;

    logic [RAW_W-1:0]   raw    [IN_COUNTERS];
    logic [TOTAL_W-1:0] preset [IN_COUNTERS];
    logic [TOTAL_W-1:0] tot    [IN_COUNTERS];
    logic [RAW_W-1:0]   rel    [IN_COUNTERS];

    assign raw[0]    = i_item.raw_count0;
    assign raw[1]    = i_item.raw_count1;
    assign preset[0] = i_item.preset0;
    assign preset[1] = i_item.preset1;

    always_comb begin
        n_total      = r_total;
        n_reload     = r_reload;
        n_stamp_sum  = r_stamp_sum;
        n_stamp_base = r_stamp_base;
        case (i_item.kind)
            KIND_SAMPLE: begin
                n_stamp_sum  = r_stamp_sum + (i_item.raw_stamp - r_stamp_base);
                n_stamp_base = i_item.raw_stamp;
                for (int i = 0; i < USED_COUNTERS; i++) begin
                    n_total[i]  = r_total[i] + {{(TOTAL_W-RAW_W){1'b0}},
                                               wrapped_delta(raw[i], r_reload[i])};
                    n_reload[i] = reload_of(n_total[i]);
                end
            end
            KIND_BIND: begin
                n_stamp_sum = '0;
                for (int i = 0; i < USED_COUNTERS; i++) begin
                    n_total[i]  = preset[i];
                    n_reload[i] = reload_of(preset[i]);
                end
            end
            KIND_RESTORE: begin
                n_stamp_base = i_item.raw_stamp;
            end
            default: begin
                // unused code: state untouched
            end
        endcase
    end

    // counters not kept read as zero
    always_comb begin
        for (int i = 0; i < IN_COUNTERS; i++) begin
            tot[i] = '0;
            rel[i] = '0;
        end
        for (int i = 0; i < USED_COUNTERS; i++) begin
            tot[i] = n_total[i];
            rel[i] = n_reload[i];
        end
    end

    assign o_result.total0      = tot[0];
    assign o_result.total1      = tot[1];
    assign o_result.stamp_total = n_stamp_sum;
    assign o_result.reload0     = rel[0];
    assign o_result.reload1     = rel[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < USED_COUNTERS; i++) begin
                r_total[i]  <= '0;
                r_reload[i] <= '0;
            end
            r_stamp_sum  <= '0;
            r_stamp_base <= '0;
        end else if (i_advance) begin
            r_total      <= n_total;
            r_reload     <= n_reload;
            r_stamp_sum  <= n_stamp_sum;
            r_stamp_base <= n_stamp_base;
        end
    end

endmodule
`default_nettype wire

/* rtl/vpc_out_buf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vpc_out_buf
// Two-entry result buffer; decouples the output stall from the core.
// ----------------------------------------------------------------------------
module vpc_out_buf
    import vpc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_data
);

    t_result    r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    logic pop;

    assign pop     = o_valid && !i_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/vpc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vpc_checker
// Port-level checks of the virtual counter extender, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vpc_checker
    import vpc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic [1:0]         i_kind,
    input wire logic [RAW_W-1:0]   i_raw_count0,
    input wire logic [RAW_W-1:0]   i_raw_count1,
    input wire logic [TOTAL_W-1:0] i_raw_stamp,
    input wire logic [TOTAL_W-1:0] i_preset0,
    input wire logic [TOTAL_W-1:0] i_preset1,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic [TOTAL_W-1:0] o_total0,
    input wire logic [TOTAL_W-1:0] o_total1,
    input wire logic [TOTAL_W-1:0] o_stamp_total,
    input wire logic [RAW_W-1:0]   o_reload0,
    input wire logic [RAW_W-1:0]   o_reload1
);

    // nothing left in flight after reset
    `VPC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

    // stalled result stays valid and holds its totals
    `VPC_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_total0) && $stable(o_total1) && $stable(o_stamp_total), "stalled result changed")

    // reload values always follow from the totals shown with them
    `VPC_ASSERT_RUN(a_reload0, i_clk, i_rst_n, o_valid |-> o_reload0 == reload_of(o_total0), "reload0 does not match total0")
    `VPC_ASSERT_RUN(a_reload1, i_clk, i_rst_n, o_valid |-> o_reload1 == reload_of(o_total1), "reload1 does not match total1")

endmodule

bind virtual_perf_counter_extend vpc_checker u_vpc_checker (.*);
`default_nettype wire
